/* rtl/one_shot_timer_table_unit_defines.svh */
// ----------------------------------------------------------------------------
// One-shot timer table assertion macros
// Shared assertion forms for the timer table RTL, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_TABLE_UNIT_DEFINES_SVH
`define ONE_SHOT_TIMER_TABLE_UNIT_DEFINES_SVH

// Checked outside of reset only.
`define OTT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define OTT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/ott_pkg.sv */
// ----------------------------------------------------------------------------
// One-shot timer table package
// Action, status and state codes and fixed field widths for the timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package ott_pkg;

   localparam int ID_W       = 16;
   localparam int DEADLINE_W = 32;
   localparam int DELAY_W    = 31;
   localparam int ENTRY_W    = DEADLINE_W + ID_W;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SET    = 2'd1,
      ACT_CANCEL = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_ASSIGNED  = 3'd0,
      ST_FIRED     = 3'd1,
      ST_CANCELLED = 3'd2,
      ST_FULL      = 3'd3,
      ST_UNKNOWN   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE        = 4'b0001,
      S_CANCEL_SCAN = 4'b0010,
      S_FIRE_SCAN   = 4'b0100,
      S_SHIFT       = 4'b1000
   } state_type;

endpackage

`default_nettype wire

/* rtl/ott_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ott_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/one_shot_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// One-shot timer table
// Holds up to TIMER_SLOTS one-shot timers against a millisecond counter.
//
// An item is taken when start is high and busy is low. req_action selects a
// tick (advance the counter by one), a set (store now plus req_delay_ms and
// return a fresh id) or a cancel (remove the timer named by req_timer_id).
// Results leave on rsp_valid for one cycle each: first the result of a set
// or a cancel, then one result per expired timer, earliest deadline first.
// rsp_last marks the final result of an item. The receiver cannot stall.
//
// The timers live in one table memory, kept packed in insertion order. Every
// pass over it goes through the single read port, one entry a cycle. A cancel
// adds a search pass, and each removed timer adds a compaction pass plus one
// more scan. busy stays high until the last result is issued, and that result
// is on the result ports in the first cycle in which busy is low.
// Reset empties the table, and clears the id counter and the millisecond
// counter; the memory itself needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_shot_timer_table_unit_defines.svh"

module one_shot_timer_table_unit #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_action,
   input  wire logic [ott_pkg::DELAY_W-1:0] req_delay_ms,
   input  wire logic [ott_pkg::ID_W-1:0]    req_timer_id,
   output logic                            rsp_valid,
   output logic [2:0]                      rsp_status,
   output logic [ott_pkg::ID_W-1:0]         rsp_result_id,
   output logic                            rsp_last
);

   localparam int ADDR_W = $clog2(TIMER_SLOTS);
   localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TIMER_SLOTS);

   ott_pkg::state_type state_ff, state_in;

   logic [ott_pkg::DEADLINE_W-1:0] now_ff, now_in;
   logic [ott_pkg::ID_W-1:0]       next_id_ff, next_id_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [CNT_W-1:0]               idx_ff, idx_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                           have_ff, have_in;
   logic [ott_pkg::DEADLINE_W-1:0] best_age_ff, best_age_in;
   logic [ADDR_W-1:0]              best_pos_ff, best_pos_in;
   logic [ott_pkg::ID_W-1:0]       best_id_ff, best_id_in;
   logic [ott_pkg::ID_W-1:0]       tid_ff, tid_in;
   logic                           held_vld_ff, held_vld_in;
   ott_pkg::status_type            held_status_ff, held_status_in;
   logic [ott_pkg::ID_W-1:0]       held_id_ff, held_id_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ott_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [ott_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_wr_addr;
   logic [ott_pkg::ENTRY_W-1:0]    mem_wr_data;
   logic [ott_pkg::ENTRY_W-1:0]    mem_rd_data;
   logic [ott_pkg::DEADLINE_W-1:0] rd_deadline;
   logic [ott_pkg::ID_W-1:0]       rd_id;
   logic [ott_pkg::DEADLINE_W-1:0] rd_age;
   logic                           issue;
   logic                           push_req;
   ott_pkg::status_type            push_status;
   logic [ott_pkg::ID_W-1:0]       push_id;
   logic                           fin_req;
   logic                           set_take;

   ott_ram #(
      .WIDTH (ott_pkg::ENTRY_W),
      .DEPTH (TIMER_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign rd_deadline = mem_rd_data[ott_pkg::ENTRY_W-1:ott_pkg::ID_W];
   assign rd_id       = mem_rd_data[ott_pkg::ID_W-1:0];
   assign rd_age      = now_ff - rd_deadline;
   assign issue       = (idx_ff < count_ff);

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      next_id_in     = next_id_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      have_in        = have_ff;
      best_age_in    = best_age_ff;
      best_pos_in    = best_pos_ff;
      best_id_in     = best_id_ff;
      tid_in         = tid_ff;
      held_vld_in    = held_vld_ff;
      held_status_in = held_status_ff;
      held_id_in     = held_id_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_wr_addr    = count_ff[ADDR_W-1:0];
      mem_wr_data    = {now_ff + {1'b0, req_delay_ms}, next_id_ff};
      push_req       = 1'b0;
      push_status    = ott_pkg::ST_ASSIGNED;
      push_id        = '0;
      fin_req        = 1'b0;

      unique case (state_ff)
         ott_pkg::S_IDLE: begin
            if (start) begin
               tid_in  = req_timer_id;
               idx_in  = '0;
               have_in = 1'b0;
               unique case (ott_pkg::action_type'(req_action))
                  ott_pkg::ACT_TICK: begin
                     now_in   = now_ff + 1'b1;
                     state_in = ott_pkg::S_FIRE_SCAN;
                  end
                  ott_pkg::ACT_SET: begin
                     push_req = 1'b1;
                     if (count_ff == SLOTS_CNT) begin
                        push_status = ott_pkg::ST_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        count_in    = count_ff + 1'b1;
                        push_status = ott_pkg::ST_ASSIGNED;
                        push_id     = next_id_ff;
                        next_id_in  = next_id_ff + 1'b1;
                     end
                     state_in = ott_pkg::S_FIRE_SCAN;
                  end
                  ott_pkg::ACT_CANCEL: begin
                     state_in = ott_pkg::S_CANCEL_SCAN;
                  end
                  default: begin
                     state_in = ott_pkg::S_FIRE_SCAN;
                  end
               endcase
            end
         end
         ott_pkg::S_CANCEL_SCAN: begin
            // The first live entry with a matching id is the one removed.
            if (rd_vld_ff && (rd_id == tid_ff)) begin
               push_req    = 1'b1;
               push_status = ott_pkg::ST_CANCELLED;
               push_id     = tid_ff;
               idx_in      = CNT_W'(rd_idx_ff) + 1'b1;
               state_in    = ott_pkg::S_SHIFT;
            end else if (issue) begin
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[ADDR_W-1:0];
               idx_in    = idx_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               push_req    = 1'b1;
               push_status = ott_pkg::ST_UNKNOWN;
               push_id     = tid_ff;
               idx_in      = '0;
               have_in     = 1'b0;
               state_in    = ott_pkg::S_FIRE_SCAN;
            end
         end
         ott_pkg::S_FIRE_SCAN: begin
            // Strictly greater age wins, so ties keep the earlier entry.
            if (rd_vld_ff && !rd_age[ott_pkg::DEADLINE_W-1] &&
                (!have_ff || (rd_age > best_age_ff))) begin
               have_in     = 1'b1;
               best_age_in = rd_age;
               best_pos_in = rd_idx_ff;
               best_id_in  = rd_id;
            end
            if (issue) begin
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[ADDR_W-1:0];
               idx_in    = idx_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               if (have_ff) begin
                  push_req    = 1'b1;
                  push_status = ott_pkg::ST_FIRED;
                  push_id     = best_id_ff;
                  idx_in      = CNT_W'(best_pos_ff) + 1'b1;
                  state_in    = ott_pkg::S_SHIFT;
               end else begin
                  fin_req  = 1'b1;
                  state_in = ott_pkg::S_IDLE;
               end
            end
         end
         ott_pkg::S_SHIFT: begin
            // Each entry read here is written one place lower in the cycle after its read.
            if (rd_vld_ff) begin
               mem_we      = 1'b1;
               mem_wr_addr = rd_idx_ff - 1'b1;
               mem_wr_data = mem_rd_data;
            end
            if (issue) begin
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[ADDR_W-1:0];
               idx_in    = idx_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               count_in = count_ff - 1'b1;
               idx_in   = '0;
               have_in  = 1'b0;
               state_in = ott_pkg::S_FIRE_SCAN;
            end
         end
         default: begin
            state_in = ott_pkg::S_IDLE;
         end
      endcase

      // A result is held back one step so that its last flag is known
      // when it goes out.
      if (push_req) begin
         if (held_vld_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = held_status_ff;
            rsp_id_in     = held_id_ff;
            rsp_last_in   = 1'b0;
         end
         held_vld_in    = 1'b1;
         held_status_in = push_status;
         held_id_in     = push_id;
      end else if (fin_req) begin
         if (held_vld_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = held_status_ff;
            rsp_id_in     = held_id_ff;
            rsp_last_in   = 1'b1;
         end
         held_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ott_pkg::S_IDLE;
         now_ff       <= '0;
         next_id_ff   <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         held_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         next_id_ff   <= next_id_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      rd_idx_ff      <= rd_idx_in;
      have_ff        <= have_in;
      best_age_ff    <= best_age_in;
      best_pos_ff    <= best_pos_in;
      best_id_ff     <= best_id_in;
      tid_ff         <= tid_in;
      held_status_ff <= held_status_in;
      held_id_ff     <= held_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy          = (state_ff != ott_pkg::S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_last      = rsp_last_ff;

   assign set_take = start && !busy && (req_action == ott_pkg::ACT_SET) &&
                     (count_ff < SLOTS_CNT);

   `OTT_ASSERT(a_count_in_range, count_ff <= SLOTS_CNT, "entry count exceeds table size")
   `OTT_ASSERT(a_rsp_from_held, rsp_valid_ff |-> $past(held_vld_ff), "result without held item")
   `OTT_ASSERT(a_idle_nothing_held, !busy |-> !held_vld_ff, "result still held while idle")
   `OTT_ASSERT(a_set_grows, set_take |=> count_ff == $past(count_ff) + 1'b1, "set not stored")
   `OTT_ASSERT_ALWAYS(a_reset_empty, reset |=> (count_ff == '0) && !busy, "not empty after reset")

endmodule

`default_nettype wire

/* tb/sv/tb_one_shot_timer_table_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// One-shot timer table testbench
// Drives tick, set, cancel and unused action items into the timer table and
// checks every result against a behavioral prediction of the table: assigned
// ids, cancellations, unknown ids, the full table and expiry in deadline
// order, directed first and then random traffic with random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_one_shot_timer_table_unit;

   localparam int SLOTS        = 16;
   localparam int DRAIN_CYCLES = 800;

   typedef struct packed {
      logic [ott_pkg::DEADLINE_W-1:0] deadline;
      logic [ott_pkg::ID_W-1:0]       id;
   } timer_entry_type;

   typedef struct {
      ott_pkg::status_type      status;
      logic [ott_pkg::ID_W-1:0] id;
      logic                     last;
   } timer_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_action = ott_pkg::ACT_TICK;
   logic [ott_pkg::DELAY_W-1:0]  req_delay_ms = '0;
   logic [ott_pkg::ID_W-1:0]     req_timer_id = '0;
   logic                         rsp_valid;
   logic [2:0]                   rsp_status;
   logic [ott_pkg::ID_W-1:0]     rsp_result_id;
   logic                         rsp_last;

   // Predicted table contents, kept in insertion order like the block's table.
   timer_entry_type                live_timers[$];
   logic [ott_pkg::DEADLINE_W-1:0] model_now = '0;
   logic [ott_pkg::ID_W-1:0]       model_next_id = '0;
   timer_result_type               pending_results[$];
   int                             mismatch_count = 0;
   bit                             gaps_enabled = 1'b1;

   one_shot_timer_table_unit #(
      .TIMER_SLOTS(SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_delay_ms(req_delay_ms),
      .req_timer_id(req_timer_id),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_result_id(rsp_result_id),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic void predict_timer_results(ott_pkg::action_type act,
                                                 logic [ott_pkg::DELAY_W-1:0] dly,
                                                 logic [ott_pkg::ID_W-1:0] tid);
      timer_result_type results[$];
      logic [ott_pkg::DEADLINE_W-1:0] age;
      logic [ott_pkg::DEADLINE_W-1:0] best_age;
      int best;
      int i;
      bit found;
      case (act)
         ott_pkg::ACT_TICK: begin
            model_now = model_now + 1;
         end
         ott_pkg::ACT_SET: begin
            if (live_timers.size() >= SLOTS) begin
               results.insert(results.size(), '{ott_pkg::ST_FULL, '0, 1'b0});
            end else begin
               live_timers.insert(live_timers.size(),
                                  {model_now + {1'b0, dly}, model_next_id});
               results.insert(results.size(),
                              '{ott_pkg::ST_ASSIGNED, model_next_id, 1'b0});
               model_next_id = model_next_id + 1'b1;
            end
         end
         ott_pkg::ACT_CANCEL: begin
            found = 1'b0;
            for (i = 0; i < live_timers.size(); i++) begin
               if (live_timers[i].id == tid) begin
                  live_timers.delete(i);
                  found = 1'b1;
                  break;
               end
            end
            results.insert(results.size(),
                           '{found ? ott_pkg::ST_CANCELLED : ott_pkg::ST_UNKNOWN,
                             tid, 1'b0});
         end
         default: ;
      endcase
      // Expired timers leave most overdue first; the strict compare keeps
      // the earliest inserted one on a tie.
      best = 0;
      while (best >= 0) begin
         best = -1;
         best_age = '0;
         for (i = 0; i < live_timers.size(); i++) begin
            age = model_now - live_timers[i].deadline;
            if (!age[ott_pkg::DEADLINE_W-1] && (best < 0 || age > best_age)) begin
               best = i;
               best_age = age;
            end
         end
         if (best >= 0) begin
            results.insert(results.size(),
                           '{ott_pkg::ST_FIRED, live_timers[best].id, 1'b0});
            live_timers.delete(best);
         end
      end
      if (results.size() > 0) begin
         results[results.size() - 1].last = 1'b1;
      end
      foreach (results[k]) begin
         pending_results.insert(pending_results.size(), results[k]);
      end
   endfunction

   task automatic send_item(ott_pkg::action_type act, logic [ott_pkg::DELAY_W-1:0] dly,
                            logic [ott_pkg::ID_W-1:0] tid);
      int gap;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= act;
      req_delay_ms <= dly;
      req_timer_id <= tid;
      do @(posedge clock); while (busy);
      predict_timer_results(act, dly, tid);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Zero delay, the longest delay, cancel hits and misses, the unused action
   // code and a tick that fires nothing.
   task automatic test_single_timers();
      logic [ott_pkg::ID_W-1:0] long_id;
      send_item(ott_pkg::ACT_SET, '0, '0);
      long_id = model_next_id;
      send_item(ott_pkg::ACT_SET, {ott_pkg::DELAY_W{1'b1}}, {ott_pkg::ID_W{1'b1}});
      send_item(ott_pkg::ACT_CANCEL, {ott_pkg::DELAY_W{1'b1}}, long_id);
      send_item(ott_pkg::ACT_CANCEL, '0, long_id);
      send_item(ott_pkg::ACT_CANCEL, {ott_pkg::DELAY_W{1'b1}}, {ott_pkg::ID_W{1'b1}});
      send_item(ott_pkg::ACT_NONE, {ott_pkg::DELAY_W{1'b1}}, {ott_pkg::ID_W{1'b1}});
      send_item(ott_pkg::ACT_TICK, '0, '0);
   endtask

   // Fill the table, overflow it, then let every timer expire in a few ticks
   // so that deadline order and insertion-order ties are both exercised.
   task automatic test_full_table();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         send_item(ott_pkg::ACT_SET, ott_pkg::DELAY_W'($urandom_range(1, 3)),
                   ott_pkg::ID_W'($urandom()));
      end
      send_item(ott_pkg::ACT_SET, ott_pkg::DELAY_W'($urandom_range(0, 3)),
                ott_pkg::ID_W'($urandom()));
      for (i = 0; i < 3; i++) begin
         send_item(ott_pkg::ACT_TICK, ott_pkg::DELAY_W'($urandom()),
                   ott_pkg::ID_W'($urandom()));
      end
   endtask

   task automatic test_random_traffic(int count);
      int n;
      int pick;
      logic [ott_pkg::DELAY_W-1:0] dly;
      logic [ott_pkg::ID_W-1:0] tid;
      for (n = 0; n < count; n++) begin
         gaps_enabled = (n < count - 20);
         if (n == count / 2) begin
            wait_results_drained();
         end
         pick = $urandom_range(0, 99);
         dly  = ott_pkg::DELAY_W'($urandom());
         tid  = ott_pkg::ID_W'($urandom());
         if (pick < 35) begin
            send_item(ott_pkg::ACT_SET, ott_pkg::DELAY_W'($urandom_range(0, 24)), tid);
         end else if (pick < 70) begin
            send_item(ott_pkg::ACT_TICK, dly, tid);
         end else if (pick < 82) begin
            if (live_timers.size() > 0) begin
               tid = live_timers[$urandom_range(0, live_timers.size() - 1)].id;
            end
            send_item(ott_pkg::ACT_CANCEL, dly, tid);
         end else if (pick < 88) begin
            send_item(ott_pkg::ACT_CANCEL, dly, tid);
         end else if (pick < 95) begin
            send_item(ott_pkg::ACT_SET, dly, tid);
         end else begin
            send_item(ott_pkg::ACT_NONE, dly, tid);
         end
      end
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none expected: status %0d id %0d last %0d",
                     $time, rsp_status, rsp_result_id, rsp_last);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_result_id !== want.id ||
                rsp_last !== want.last) begin
               mismatch_count++;
               $display("%0t: expected status %0d id %0d last %0d, got status %0d id %0d last %0d",
                        $time, want.status, want.id, want.last,
                        rsp_status, rsp_result_id, rsp_last);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_timers();
      test_full_table();
      test_random_traffic(103);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_one_shot_timer_table_unit OK");
      end else begin
         $display("tb_one_shot_timer_table_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("tb_one_shot_timer_table_unit NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/ott_pkg.sv
rtl/ott_ram.sv
rtl/one_shot_timer_table_unit.sv
tb/sv/tb_one_shot_timer_table_unit.sv
